// ----- rtl/core/ihp_pkg.sv -----
// Shared types and codes of the indexed min-heap.
package ihp_pkg;

    localparam int ID_W     = 10;
    localparam int IN_KEY_W = 32;
    localparam int CNT_OUT_W = 11;
    localparam int ID_CMP_W = 21;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_DECREASE = 2'd1,
        OP_POP      = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_FULL   = 2'd1,
        STS_EMPTY  = 2'd2,
        STS_ABSENT = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INS_CHK,
        S_DEC_CHK,
        S_DEC_CMP,
        S_UP_REQ,
        S_UP_CMP,
        S_POP_TOP,
        S_POP_LAST,
        S_DN_REQ,
        S_DN_L,
        S_DN_R,
        S_EMIT
    } state_t;

endpackage

// ----- rtl/core/ihp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ihp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/ihp_cmp.sv -----
// Shared signed key comparator.
module ihp_cmp #(
    parameter int WIDTH = 32
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic             lt
);

    // signed less-than: flip the sign bits and compare unsigned
    assign lt = {~a[WIDTH-1], a[WIDTH-2:0]} < {~b[WIDTH-1], b[WIDTH-2:0]};

endmodule

// ----- rtl/core/indexed_min_heap.sv -----
// Top level of the indexed binary min-heap with id-to-slot map.
//
// Indexed binary min-heap of (id, signed key) pairs. Each request on the
// s_ channel (insert, decrease key, pop minimum) yields one result on the
// m_ channel with status, popped id and key, and the count afterwards.
// Heap entries and the id-to-slot map live in two single-port-read RAMs;
// one signed comparator is reused by a sequencer for every step. A sift
// going up passes S_UP_REQ and S_UP_CMP per level; a sift going down
// passes S_DN_REQ and S_DN_L, and S_DN_R where a right child exists
// (left and right child are read one after the other through the one
// heap read port). s_tready is low while a request is in work. After
// reset the map RAM is cleared one entry a cycle, all NUM_IDS entries,
// before the first request is taken. A finished result waits in an
// output register, so the next request is taken while it is still
// pending; a second result that finds the register still occupied holds
// the sequencer until it drains.
module indexed_min_heap
    import ihp_pkg::*;
#(
    parameter int CAPACITY  = 1024,
    parameter int NUM_IDS   = 1024,
    parameter int KEY_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // op[1:0], element_id[11:2], key[43:12], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // status[1:0], out_id[11:2], out_key[43:12], count[54:44]
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = $clog2(NUM_IDS);
    localparam int DN_W   = SLOT_W + 2;
    localparam int HW     = KEY_WIDTH + ID_W;
    localparam int MW     = SLOT_W + 1;

    // unpack the request
    logic [1:0]           s_op;
    logic [ID_W-1:0]      s_id;
    logic [KEY_WIDTH-1:0] s_key;
    assign s_op  = s_tdata[1:0];
    assign s_id  = s_tdata[11:2];
    assign s_key = KEY_WIDTH'($signed(s_tdata[43:12]));

    state_t               state_reg, state_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [KEY_WIDTH-1:0] mkey_reg, mkey_next;
    logic [ID_W-1:0]      mid_reg, mid_next;
    logic [KEY_WIDTH-1:0] bkey_reg, bkey_next;
    logic [ID_W-1:0]      bid_reg, bid_next;
    logic [SLOT_W-1:0]    bslot_reg, bslot_next;
    logic                 found_reg, found_next;
    status_t              res_status_reg, res_status_next;
    logic [ID_W-1:0]      res_id_reg, res_id_next;
    logic [IN_KEY_W-1:0]  res_key_reg, res_key_next;
    logic [IDX_W-1:0]     clr_reg, clr_next;
    logic                 m_valid_reg, m_valid_next;
    logic [55:0]          m_data_reg, m_data_next;

    // RAM ports
    logic              heap_we, map_we;
    logic [SLOT_W-1:0] heap_waddr, heap_raddr;
    logic [HW-1:0]     heap_wdata, heap_rdata;
    logic [IDX_W-1:0]  map_waddr, map_raddr;
    logic [MW-1:0]     map_wdata, map_rdata;

    logic [KEY_WIDTH-1:0] hrd_key;
    logic [ID_W-1:0]      hrd_id;
    logic                 map_present;
    logic [SLOT_W-1:0]    map_slot;
    assign hrd_key     = heap_rdata[HW-1:ID_W];
    assign hrd_id      = heap_rdata[ID_W-1:0];
    assign map_present = map_rdata[SLOT_W];
    assign map_slot    = map_rdata[SLOT_W-1:0];

    // shared comparator
    logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
    logic                 cmp_lt;

    ihp_cmp #(.WIDTH(KEY_WIDTH)) u_cmp (.a(cmp_a), .b(cmp_b), .lt(cmp_lt));

    ihp_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap (
        .aclk(aclk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
        .raddr(heap_raddr), .rdata(heap_rdata)
    );

    ihp_ram #(.WIDTH(MW), .DEPTH(NUM_IDS)) u_map (
        .aclk(aclk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .raddr(map_raddr), .rdata(map_rdata)
    );

    logic             s_fire, out_free;
    logic             id_bad;
    logic [DN_W-1:0]  left_idx, right_idx, count_ext;
    logic             r_avail;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign id_bad    = ID_CMP_W'(s_id) >= ID_CMP_W'(NUM_IDS);
    assign left_idx  = {1'b0, slot_reg, 1'b1};
    assign right_idx = DN_W'(bslot_reg) + DN_W'(1);
    assign count_ext = DN_W'(count_reg);
    assign r_avail   = right_idx < count_ext;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_reg == IDX_W'(NUM_IDS - 1)) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_fire) begin
                    unique case (s_op)
                        OP_INSERT: begin
                            if (id_bad || count_reg >= CNT_W'(CAPACITY)) state_next = S_EMIT;
                            else                                          state_next = S_INS_CHK;
                        end
                        OP_DECREASE: state_next = id_bad ? S_EMIT : S_DEC_CHK;
                        OP_POP:      state_next = (count_reg == '0) ? S_EMIT : S_POP_TOP;
                        default:     state_next = S_EMIT;
                    endcase
                end
            end
            S_INS_CHK:  state_next = map_present ? S_EMIT : S_UP_REQ;
            S_DEC_CHK:  state_next = map_present ? S_DEC_CMP : S_EMIT;
            S_DEC_CMP:  state_next = cmp_lt ? S_UP_REQ : S_EMIT;
            S_UP_REQ:   state_next = (slot_reg == '0) ? S_EMIT : S_UP_CMP;
            S_UP_CMP:   state_next = cmp_lt ? S_UP_REQ : S_EMIT;
            S_POP_TOP:  state_next = (count_reg == CNT_W'(1)) ? S_EMIT : S_POP_LAST;
            S_POP_LAST: state_next = S_DN_REQ;
            S_DN_REQ:   state_next = (left_idx >= count_ext) ? S_EMIT : S_DN_L;
            S_DN_L: begin
                if (r_avail)     state_next = S_DN_R;
                else if (cmp_lt) state_next = S_DN_REQ;
                else             state_next = S_EMIT;
            end
            S_DN_R:     state_next = (cmp_lt || found_reg) ? S_DN_REQ : S_EMIT;
            S_EMIT:     state_next = out_free ? S_IDLE : S_EMIT;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath, RAM controls and comparator operands
    always_comb begin
        id_next         = id_reg;
        key_next        = key_reg;
        count_next      = count_reg;
        slot_next       = slot_reg;
        mkey_next       = mkey_reg;
        mid_next        = mid_reg;
        bkey_next       = bkey_reg;
        bid_next        = bid_reg;
        bslot_next      = bslot_reg;
        found_next      = found_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_key_next    = res_key_reg;
        clr_next        = clr_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        heap_we         = 1'b0;
        heap_waddr      = slot_reg;
        heap_wdata      = {mkey_reg, mid_reg};
        heap_raddr      = '0;
        map_we          = 1'b0;
        map_waddr       = IDX_W'(mid_reg);
        map_wdata       = {1'b1, slot_reg};
        map_raddr       = IDX_W'(s_id);
        cmp_a           = hrd_key;
        cmp_b           = mkey_reg;
        unique case (state_reg)
            S_CLEAR: begin
                // sweep the map, one id a cycle
                map_we    = 1'b1;
                map_waddr = clr_reg;
                map_wdata = '0;
                clr_next  = clr_reg + IDX_W'(1);
            end
            S_IDLE: begin
                if (s_fire) begin
                    id_next         = s_id;
                    key_next        = s_key;
                    res_status_next = STS_OK;
                    res_id_next     = '0;
                    res_key_next    = '0;
                    unique case (s_op)
                        OP_INSERT: begin
                            if (id_bad)                              res_status_next = STS_ABSENT;
                            else if (count_reg >= CNT_W'(CAPACITY)) res_status_next = STS_FULL;
                        end
                        OP_DECREASE: begin
                            if (id_bad) res_status_next = STS_ABSENT;
                        end
                        OP_POP: begin
                            if (count_reg == '0) res_status_next = STS_EMPTY;
                        end
                        default: ;
                    endcase
                end
            end
            S_INS_CHK: begin
                // new entry goes to the last slot
                if (!map_present) begin
                    mkey_next  = key_reg;
                    mid_next   = id_reg;
                    slot_next  = SLOT_W'(count_reg);
                    count_next = count_reg + CNT_W'(1);
                end
            end
            S_DEC_CHK: begin
                heap_raddr = map_slot;
                slot_next  = map_slot;
                if (!map_present) res_status_next = STS_ABSENT;
            end
            S_DEC_CMP: begin
                cmp_a = key_reg;
                cmp_b = hrd_key;
                if (cmp_lt) begin
                    mkey_next = key_reg;
                    mid_next  = id_reg;
                end
            end
            S_UP_REQ: begin
                heap_raddr = (slot_reg - SLOT_W'(1)) >> 1;
                if (slot_reg == '0) begin
                    heap_we = 1'b1;
                    map_we  = 1'b1;
                end
            end
            S_UP_CMP: begin
                // parent strictly greater: pull it down one level
                cmp_a   = mkey_reg;
                cmp_b   = hrd_key;
                heap_we = 1'b1;
                map_we  = 1'b1;
                if (cmp_lt) begin
                    heap_wdata = heap_rdata;
                    map_waddr  = IDX_W'(hrd_id);
                    slot_next  = (slot_reg - SLOT_W'(1)) >> 1;
                end
            end
            S_POP_TOP: begin
                res_id_next  = hrd_id;
                res_key_next = IN_KEY_W'($signed(hrd_key));
                map_we       = 1'b1;
                map_waddr    = IDX_W'(hrd_id);
                map_wdata    = '0;
                count_next   = count_reg - CNT_W'(1);
                heap_raddr   = SLOT_W'(count_reg - CNT_W'(1));
            end
            S_POP_LAST: begin
                mkey_next = hrd_key;
                mid_next  = hrd_id;
                slot_next = '0;
            end
            S_DN_REQ: begin
                heap_raddr = SLOT_W'(left_idx);
                bslot_next = SLOT_W'(left_idx);
                if (left_idx >= count_ext) begin
                    heap_we = 1'b1;
                    map_we  = 1'b1;
                end
            end
            S_DN_L: begin
                heap_raddr = SLOT_W'(right_idx);
                found_next = cmp_lt;
                bkey_next  = cmp_lt ? hrd_key : mkey_reg;
                bid_next   = hrd_id;
                if (!r_avail) begin
                    heap_we = 1'b1;
                    map_we  = 1'b1;
                    if (cmp_lt) begin
                        heap_wdata = heap_rdata;
                        map_waddr  = IDX_W'(hrd_id);
                        slot_next  = bslot_reg;
                    end
                end
            end
            S_DN_R: begin
                // right wins only if below the best so far
                cmp_b   = bkey_reg;
                heap_we = 1'b1;
                map_we  = 1'b1;
                if (cmp_lt) begin
                    heap_wdata = heap_rdata;
                    map_waddr  = IDX_W'(hrd_id);
                    slot_next  = SLOT_W'(right_idx);
                end else if (found_reg) begin
                    heap_wdata = {bkey_reg, bid_reg};
                    map_waddr  = IDX_W'(bid_reg);
                    slot_next  = bslot_reg;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, CNT_OUT_W'(count_reg), res_key_reg,
                                    res_id_reg, res_status_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            count_reg   <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg         <= id_next;
        key_reg        <= key_next;
        slot_reg       <= slot_next;
        mkey_reg       <= mkey_next;
        mid_reg        <= mid_next;
        bkey_reg       <= bkey_next;
        bid_reg        <= bid_next;
        bslot_reg      <= bslot_next;
        found_reg      <= found_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_key_reg    <= res_key_next;
        m_data_reg     <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("heap count above capacity");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("request accepted while busy");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && res_status_reg == STS_FULL) |-> count_reg == CNT_W'(CAPACITY))
        else $error("full status with heap not full");

    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_POP_TOP) |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("pop did not shrink the heap");
`endif

endmodule
